>>> rtl/spts_pkg.sv
`default_nettype none

package spts_pkg;

  localparam int BIN_W      = 10;
  localparam int MAG_W      = 32;
  localparam int HW_W       = 4;
  localparam int STREAK_W   = 7;
  localparam int DEST_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_BIN_COUNT = 1024;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CENTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_CENTER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_CENTER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HALFWIDTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT  = 3'd7;

  localparam logic [BIN_W-1:0]    RST_MIN_BIN        = 10'd10;
  localparam logic [BIN_W-1:0]    RST_MAX_BIN        = 10'd30;
  localparam logic [MAG_W-1:0]    RST_PEAK_THRESHOLD = 32'd10000;
  localparam logic [BIN_W-1:0]    RST_GREEN_CENTER   = 10'd19;
  localparam logic [BIN_W-1:0]    RST_RED_CENTER     = 10'd26;
  localparam logic [BIN_W-1:0]    RST_BLUE_CENTER    = 10'd23;
  localparam logic [HW_W-1:0]     RST_BAND_HALFWIDTH = 4'd1;
  localparam logic [STREAK_W-1:0] RST_CONFIRM_COUNT  = 7'd9;

  localparam logic [DEST_W-1:0] BAND_NONE  = 2'd0;
  localparam logic [DEST_W-1:0] BAND_GREEN = 2'd1;
  localparam logic [DEST_W-1:0] BAND_RED   = 2'd2;
  localparam logic [DEST_W-1:0] BAND_BLUE  = 2'd3;

  localparam logic [STREAK_W-1:0] STREAK_MAX = 7'd127;

  typedef struct packed {
    logic [BIN_W-1:0]    min_bin;
    logic [BIN_W-1:0]    max_bin;
    logic [MAG_W-1:0]    peak_threshold;
    logic [BIN_W-1:0]    green_center;
    logic [BIN_W-1:0]    red_center;
    logic [BIN_W-1:0]    blue_center;
    logic [HW_W-1:0]     band_halfwidth;
    logic [STREAK_W-1:0] confirm_count;
  } cfg_t;

  // summary of one finished frame
  typedef struct packed {
    logic             peak_seen;
    logic [BIN_W-1:0] peak_index;
  } frame_t;

  function automatic logic in_band(input logic [BIN_W-1:0] bin,
                                   input logic [BIN_W-1:0] centre,
                                   input logic [HW_W-1:0]  hw);
    logic [BIN_W:0] lo_sum;
    logic [BIN_W:0] hi_sum;
    lo_sum = {1'b0, bin} + {{(BIN_W+1-HW_W){1'b0}}, hw};
    hi_sum = {1'b0, centre} + {{(BIN_W+1-HW_W){1'b0}}, hw};
    return (lo_sum >= {1'b0, centre}) && ({1'b0, bin} <= hi_sum);
  endfunction

endpackage

`default_nettype wire

>>> rtl/spts_if.sv
`default_nettype none

interface spts_bin_if import spts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             last_bin;

  modport source (output valid, output magnitude, output last_bin, input ready);
  modport sink (input valid, input magnitude, input last_bin, output ready);
endinterface

interface spts_res_if import spts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DEST_W-1:0]   destination;
  logic                peak_valid;
  logic [BIN_W-1:0]    peak_bin;
  logic [STREAK_W-1:0] streak;

  modport source (output valid, output destination, output peak_valid,
                  output peak_bin, output streak, input ready);
  modport sink (input valid, input destination, input peak_valid,
                input peak_bin, input streak, output ready);
endinterface

`default_nettype wire

>>> rtl/spts_front.sv
`default_nettype none

module spts_front import spts_pkg::*; #(
  parameter int BIN_COUNT = DEF_BIN_COUNT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  spts_bin_if.sink     bin_in,
  input  wire logic    q_full,
  output logic         push,
  output frame_t       push_frame
);

  localparam int CNT_W = $clog2(BIN_COUNT);
  localparam int CMP_W = (CNT_W > BIN_W) ? CNT_W : BIN_W;

  logic [CNT_W-1:0] bin_count;
  logic [MAG_W-1:0] running_max;
  logic [BIN_W-1:0] running_index;
  logic             peak_seen;

  logic [CMP_W-1:0] bin_ext;
  logic             in_range;
  logic [MAG_W-1:0] best;
  logic             hit;
  logic [BIN_W-1:0] cur_index;
  logic             accept;

  assign bin_in.ready = !q_full;
  assign accept       = bin_in.valid && bin_in.ready;

  assign bin_ext   = CMP_W'(bin_count);
  assign in_range  = (bin_ext >= CMP_W'(cfg.min_bin)) && (bin_ext <= CMP_W'(cfg.max_bin));
  assign best      = peak_seen ? running_max : cfg.peak_threshold;
  assign hit       = in_range && (bin_in.magnitude > best);
  assign cur_index = bin_ext[BIN_W-1:0];

  assign push                  = accept && bin_in.last_bin;
  assign push_frame.peak_seen  = peak_seen || hit;
  assign push_frame.peak_index = hit ? cur_index : running_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count     <= '0;
      running_index <= '0;
      peak_seen     <= 1'b0;
    end else if (accept) begin
      if (bin_in.last_bin) begin
        bin_count     <= '0;
        running_index <= '0;
        peak_seen     <= 1'b0;
      end else begin
        if (hit) begin
          running_index <= cur_index;
          peak_seen     <= 1'b1;
        end
        if (bin_count == CNT_W'(BIN_COUNT - 1)) begin
          bin_count <= '0;
        end else begin
          bin_count <= bin_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      running_max <= bin_in.magnitude;
    end
  end

endmodule

`default_nettype wire

>>> rtl/spts_queue.sv
`default_nettype none

module spts_queue import spts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire frame_t push_frame,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output frame_t      head,
  output logic [$clog2(QUEUE_DEPTH):0] count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

>>> rtl/spts_back.sv
`default_nettype none

module spts_back import spts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_not_empty,
  input  wire frame_t head,
  output logic        pop,
  spts_res_if.source  res_out
);

  logic [DEST_W-1:0]   tracked_band;
  logic [STREAK_W-1:0] streak_count;
  logic [DEST_W-1:0]   chosen_dest;

  logic [DEST_W-1:0]   band;
  logic [DEST_W-1:0]   tracked_band_next;
  logic [STREAK_W-1:0] streak_count_next;
  logic [DEST_W-1:0]   chosen_dest_next;

  assign pop = q_not_empty && (!res_out.valid || res_out.ready);

  always_comb begin
    band = BAND_NONE;
    if (head.peak_seen) begin
      if (in_band(head.peak_index, cfg.green_center, cfg.band_halfwidth)) begin
        band = BAND_GREEN;
      end else if (in_band(head.peak_index, cfg.red_center, cfg.band_halfwidth)) begin
        band = BAND_RED;
      end else if (in_band(head.peak_index, cfg.blue_center, cfg.band_halfwidth)) begin
        band = BAND_BLUE;
      end
    end
  end

  always_comb begin
    tracked_band_next = tracked_band;
    streak_count_next = streak_count;
    chosen_dest_next  = chosen_dest;
    if (band == BAND_NONE) begin
      streak_count_next = '0;
      chosen_dest_next  = BAND_NONE;
    end else if (tracked_band == band && streak_count > cfg.confirm_count) begin
      chosen_dest_next = band;
    end else if (tracked_band != band) begin
      tracked_band_next = band;
      streak_count_next = STREAK_W'(1);
    end else if (streak_count < STREAK_MAX) begin
      streak_count_next = streak_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_band  <= BAND_NONE;
      streak_count  <= '0;
      chosen_dest   <= BAND_NONE;
      res_out.valid <= 1'b0;
    end else begin
      if (pop) begin
        tracked_band  <= tracked_band_next;
        streak_count  <= streak_count_next;
        chosen_dest   <= chosen_dest_next;
        res_out.valid <= 1'b1;
      end else if (res_out.ready) begin
        res_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_out.destination <= chosen_dest_next;
      res_out.peak_valid  <= head.peak_seen;
      res_out.peak_bin    <= head.peak_seen ? head.peak_index : '0;
      res_out.streak      <= streak_count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/spectral_peak_tone_selector.sv
`default_nettype none

// channel   direction  payload                                    transfer
// bin_in    in         magnitude[31:0], last_bin                  valid && ready
// res_out   out        destination[1:0], peak_valid,              valid && ready
//                      peak_bin[9:0], streak[6:0]
// cfg       in         cfg_index[2:0], cfg_data[31:0]             cfg_we
//
// one bin per cycle unless the queue is full; argmax compare is combinational
// a frame summary enters a 4-entry queue on the last bin; the band
// classifier pops it and registers the result once res_out can take it
// bin_in stalls only when the queue is full; res_out stalls only hold the
// output register and the queue, bins keep flowing meanwhile
// rst is synchronous and restores the register defaults and clears state

module spectral_peak_tone_selector import spts_pkg::*; #(
  parameter int BIN_COUNT = DEF_BIN_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  spts_bin_if.sink                   bin_in,
  spts_res_if.source                 res_out,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  frame_t push_frame;
  logic   pop;
  logic   q_full;
  logic   q_not_empty;
  frame_t head;
  logic [$clog2(QUEUE_DEPTH):0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_bin        <= RST_MIN_BIN;
      cfg.max_bin        <= RST_MAX_BIN;
      cfg.peak_threshold <= RST_PEAK_THRESHOLD;
      cfg.green_center   <= RST_GREEN_CENTER;
      cfg.red_center     <= RST_RED_CENTER;
      cfg.blue_center    <= RST_BLUE_CENTER;
      cfg.band_halfwidth <= RST_BAND_HALFWIDTH;
      cfg.confirm_count  <= RST_CONFIRM_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_BIN:        cfg.min_bin        <= cfg_data[BIN_W-1:0];
        CFG_MAX_BIN:        cfg.max_bin        <= cfg_data[BIN_W-1:0];
        CFG_PEAK_THRESHOLD: cfg.peak_threshold <= cfg_data[MAG_W-1:0];
        CFG_GREEN_CENTER:   cfg.green_center   <= cfg_data[BIN_W-1:0];
        CFG_RED_CENTER:     cfg.red_center     <= cfg_data[BIN_W-1:0];
        CFG_BLUE_CENTER:    cfg.blue_center    <= cfg_data[BIN_W-1:0];
        CFG_BAND_HALFWIDTH: cfg.band_halfwidth <= cfg_data[HW_W-1:0];
        CFG_CONFIRM_COUNT:  cfg.confirm_count  <= cfg_data[STREAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spts_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .bin_in     (bin_in),
    .q_full     (q_full),
    .push       (push),
    .push_frame (push_frame)
  );

  spts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head),
    .count      (q_count)
  );

  spts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .res_out     (res_out)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH))
    else $error("frame queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full && !pop |=> q_full || !$past(push))
    else $error("frame pushed into full queue");

  a_dest_needs_peak: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.destination != BAND_NONE |-> res_out.peak_valid
      && res_out.streak != '0)
    else $error("destination set without a peak");

  a_no_peak_bin_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.peak_valid |-> res_out.peak_bin == '0
      && res_out.streak == '0)
    else $error("empty frame carries peak data");

endmodule

`default_nettype wire
